// File: hdl/bu4x_pkg.sv
// shared types, constants and arithmetic helpers of the 4x bilinear upsampler
`default_nettype none

package bu4x_pkg;

  localparam int LOW_SIDE    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int IN_W        = 16;
  localparam int COORD_W     = 10;
  localparam int VALUE_W     = 16;
  localparam int IDX_W       = $clog2(LOW_SIDE);
  localparam int CSUM_W      = IDX_W + 3;
  localparam int K_W         = 3;
  localparam int W_W         = 4;
  localparam int H_W         = SAMPLE_BITS + 3;
  localparam int ACC_W       = SAMPLE_BITS + 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [K_W-1:0]         koff_t;
  typedef logic [W_W-1:0]         wgt_t;
  typedef logic [H_W-1:0]         hsum_t;
  typedef logic [ACC_W-1:0]       acc_t;

  // offsets within the 6x6 output window around a sample
  localparam koff_t K_FIRST      = 3'd0;
  localparam koff_t K_EDGE_FIRST = 3'd2;
  localparam koff_t K_LAST       = 3'd3;
  localparam koff_t K_CLAMP      = 3'd4;
  localparam koff_t K_EDGE_LAST  = 3'd5;

  localparam wgt_t    W_FULL     = 4'd8;
  localparam idx_t    IDX_LAST   = IDX_W'(LOW_SIDE - 1);
  localparam acc_t    ROUND_HALF = ACC_W'(32);
  localparam sample_t SIGN_BIT   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // operands of one sample, kept in offset binary
  typedef struct packed {
    sample_t q00;
    sample_t q01;
    sample_t q10;
    sample_t q11;
    idx_t    col;
    idx_t    row;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_msg_t;

  function automatic sample_t to_offset(sample_t s);
    return s ^ SIGN_BIT;
  endfunction

  function automatic logic [COORD_W-1:0] coord(idx_t idx, koff_t k);
    logic [CSUM_W-1:0] t;
    t = {idx, 2'b00} + CSUM_W'(k) - CSUM_W'(2);
    return COORD_W'(t);
  endfunction

  // eighth-weight of the current-side tap, zero when both taps clamp to it
  function automatic wgt_t tap_weight(koff_t k, logic clamp);
    return clamp ? '0 : {1'b0, k[1:0], 1'b1};
  endfunction

  function automatic hsum_t hblend(wgt_t w, sample_t a, sample_t b);
    return H_W'(W_FULL - w) * H_W'(a) + H_W'(w) * H_W'(b);
  endfunction

  function automatic acc_t vblend(wgt_t w, hsum_t a, hsum_t b);
    return ACC_W'(W_FULL - w) * ACC_W'(a) + ACC_W'(w) * ACC_W'(b);
  endfunction

endpackage

`default_nettype wire

// File: hdl/bu4x_front.sv
// front end: sample intake, line buffer, neighbor registers and raster position
`default_nettype none

module bu4x_front import bu4x_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_stall_o,
  input  logic signed [IN_W-1:0] sample_value_i,
  input  logic                   queue_full_i,
  output job_msg_t               push_o
);

  sample_t line_mem [LOW_SIDE];
  sample_t raw;
  logic    accept;
  logic    pushed;
  idx_t    col_q, col_d;
  idx_t    row_q, row_d;
  sample_t rd_q;
  sample_t left_q;
  logic    fvalid_q, fvalid_d;
  sample_t fraw_q, fleft_q, fupleft_q;
  idx_t    fcol_q, frow_q;

  assign raw            = SAMPLE_BITS'($unsigned(sample_value_i));
  assign sample_stall_o = fvalid_q && queue_full_i;
  assign accept         = sample_valid_i && !sample_stall_o;
  assign pushed         = fvalid_q && !queue_full_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= raw;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == IDX_LAST) begin
        col_d = '0;
        row_d = (row_q == IDX_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    fvalid_d = fvalid_q;
    if (accept) begin
      fvalid_d = 1'b1;
    end else if (pushed) begin
      fvalid_d = 1'b0;
    end
  end

  // rd_q keeps the last read, so it is also the up-left neighbor of the next sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      fvalid_q <= 1'b0;
      rd_q     <= '0;
      left_q   <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      fvalid_q <= fvalid_d;
      if (accept) begin
        rd_q   <= line_mem[col_q];
        left_q <= raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fraw_q    <= raw;
      fleft_q   <= left_q;
      fupleft_q <= rd_q;
      fcol_q    <= col_q;
      frow_q    <= row_q;
    end
  end

  always_comb begin
    push_o.valid   = fvalid_q;
    push_o.job.q00 = to_offset(fupleft_q);
    push_o.job.q01 = to_offset(rd_q);
    push_o.job.q10 = to_offset(fleft_q);
    push_o.job.q11 = to_offset(fraw_q);
    push_o.job.col = fcol_q;
    push_o.job.row = frow_q;
  end

endmodule

`default_nettype wire

// File: hdl/bu4x_queue.sv
// short job queue between front end and back end
`default_nettype none

module bu4x_queue import bu4x_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_msg_t push_i,
  output logic     full_o,
  input  logic     pop_i,
  output job_msg_t head_o
);

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i.valid && !full_o;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = slots_q[rd_q];

  always_comb begin
    unique case ({do_push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_i.job;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: hdl/bu4x_back.sv
// back end: output window sequencer and two-stage blend pipeline
`default_nettype none

module bu4x_back import bu4x_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  job_msg_t                  head_i,
  output logic                      pop_o,
  output logic                      result_valid_o,
  input  logic                      result_stall_i,
  output logic [COORD_W-1:0]        out_x_o,
  output logic [COORD_W-1:0]        out_y_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      last_of_run_o
);

  job_t  j;
  koff_t xs, xe, ys, ye, kx, ky;
  koff_t kx_q, kx_d, ky_q, ky_d;
  logic  busy_q, busy_d;
  logic  row_end, last;
  logic  out_ready, s1_ready, issue;
  logic  cx, cy;
  wgt_t  fx, fy;
  hsum_t h0, h1;

  logic               s1_valid_q;
  hsum_t              s1_ha_q, s1_hb_q;
  wgt_t               s1_fy_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q;
  logic               s1_last_q;

  acc_t               acc;
  sample_t            val;
  logic               res_valid_q;
  logic [COORD_W-1:0] res_x_q, res_y_q;
  logic [VALUE_W-1:0] res_value_q;
  logic               res_last_q;

  assign j  = head_i.job;
  assign xs = (j.col == '0)       ? K_EDGE_FIRST : K_FIRST;
  assign xe = (j.col == IDX_LAST) ? K_EDGE_LAST  : K_LAST;
  assign ys = (j.row == '0)       ? K_EDGE_FIRST : K_FIRST;
  assign ye = (j.row == IDX_LAST) ? K_EDGE_LAST  : K_LAST;
  assign kx = busy_q ? kx_q : xs;
  assign ky = busy_q ? ky_q : ys;

  assign row_end   = (kx == xe);
  assign last      = row_end && (ky == ye);
  assign out_ready = !res_valid_q || !result_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign issue     = head_i.valid && s1_ready;
  assign pop_o     = issue && last;

  always_comb begin
    busy_d = busy_q;
    kx_d   = kx_q;
    ky_d   = ky_q;
    if (issue) begin
      busy_d = !last;
      kx_d   = row_end ? xs : kx + 1'b1;
      ky_d   = row_end ? ky + 1'b1 : ky;
    end
  end

  // at the image border both taps fall on the current sample
  assign cx = (j.col == '0) || (kx >= K_CLAMP);
  assign cy = (j.row == '0) || (ky >= K_CLAMP);
  assign fx = tap_weight(kx, cx);
  assign fy = tap_weight(ky, cy);
  assign h0 = hblend(fx, cx ? j.q01 : j.q00, j.q01);
  assign h1 = hblend(fx, cx ? j.q11 : j.q10, j.q11);

  assign acc = vblend(s1_fy_q, s1_ha_q, s1_hb_q) + ROUND_HALF;
  assign val = acc[ACC_W-1 -: SAMPLE_BITS] ^ SIGN_BIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      kx_q        <= '0;
      ky_q        <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      kx_q   <= kx_d;
      ky_q   <= ky_d;
      if (s1_ready) begin
        s1_valid_q <= issue;
      end
      if (out_ready) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ha_q   <= cy ? h1 : h0;
      s1_hb_q   <= h1;
      s1_fy_q   <= fy;
      s1_x_q    <= coord(j.col, kx);
      s1_y_q    <= coord(j.row, ky);
      s1_last_q <= last;
    end
    if (out_ready && s1_valid_q) begin
      res_x_q     <= s1_x_q;
      res_y_q     <= s1_y_q;
      res_value_q <= VALUE_W'(val);
      res_last_q  <= s1_last_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_x_o        = res_x_q;
  assign out_y_o        = res_y_q;
  assign out_value_o    = res_value_q;
  assign last_of_run_o  = res_last_q;

`ifndef NO_ASSERTIONS
  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> head_i.valid)
    else $error("window sequencer busy without a queued job");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ready |=> $stable(s1_ha_q) && $stable(s1_x_q) && $stable(s1_last_q))
    else $error("blend stage changed while blocked");
`endif

endmodule

`default_nettype wire

// File: hdl/bilinear_upsample_4x.sv
// top level of the streaming 4x bilinear upsampler
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+----------------------------------
//   sample   | sample_valid_i / sample_stall_o  | sample_value_i
//   result   | result_valid_o / result_stall_i  | out_x_o out_y_o out_value_o
//            |                                  | last_of_run_o
//
// one result per cycle from the back end window sequencer unless results stall,
// so a sample yields 4 to 36 results, 16 inside the image; up to three accepted
// samples wait in the front register and the queue
// first results pass the front register, queue, blend stage and result register
// reset clears counters, neighbor registers and queue; the line buffer is not
// cleared since the first row never uses what it reads from it
// a result stall fills blend pipe, queue and front register, then stalls samples
`default_nettype none

module bilinear_upsample_4x import bu4x_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_valid_i,
  output logic                      sample_stall_o,
  input  logic signed [IN_W-1:0]    sample_value_i,
  output logic                      result_valid_o,
  input  logic                      result_stall_i,
  output logic [COORD_W-1:0]        out_x_o,
  output logic [COORD_W-1:0]        out_y_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      last_of_run_o
);

  job_msg_t push;
  job_msg_t head;
  logic     queue_full;
  logic     pop;

  bu4x_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_value_i (sample_value_i),
    .queue_full_i   (queue_full),
    .push_o         (push)
  );

  bu4x_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .pop_i  (pop),
    .head_o (head)
  );

  bu4x_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_value_o    (out_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for bilinear_upsample_4x: streams the opening samples of an image and checks every pixel
module tb_top;
  import bu4x_pkg::*;

  localparam int IMAGE_SAMPLES = LOW_SIDE * LOW_SIDE;
  localparam int TOTAL_SAMPLES = 170;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VALUE_W-1:0] value;
    logic               last;
  } pixel_t;

  class pixel_scoreboard;
    bit [SAMPLE_BITS-1:0] line_buf [LOW_SIDE];
    bit [SAMPLE_BITS-1:0] left;
    bit [SAMPLE_BITS-1:0] up_left;
    int                   row_idx;
    int                   col_idx;
    pixel_t               expected_pixels [$];
    int                   mismatches;

    // side of both taps (1 = current sample) and eighth-weight of the second tap
    function void tap_side(int p, int cur, output int ia, output int ib, output int f);
      int i0;
      int a;
      int b;
      i0 = (p + 2) / 4 - 1;
      f  = 2 * p - 3 - 8 * i0;
      a  = (i0 < 0) ? 0 : ((i0 > LOW_SIDE - 1) ? LOW_SIDE - 1 : i0);
      b  = (i0 + 1 > LOW_SIDE - 1) ? LOW_SIDE - 1 : i0 + 1;
      ia = (a == cur);
      ib = (b == cur);
    endfunction

    function void note_sample(sample_t raw);
      int unsigned          q [2][2];
      int unsigned          acc;
      int                   x0, x1, y0, y1, x, y;
      int                   xa, xb, ya, yb, fx, fy;
      bit [SAMPLE_BITS-1:0] up;
      bit [SAMPLE_BITS-1:0] res;
      pixel_t               px;
      up = line_buf[col_idx];
      q[0][0] = up_left ^ SIGN_BIT;
      q[0][1] = up ^ SIGN_BIT;
      q[1][0] = left ^ SIGN_BIT;
      q[1][1] = raw ^ SIGN_BIT;
      x0 = (col_idx == 0) ? 0 : 4 * col_idx - 2;
      x1 = (col_idx == LOW_SIDE - 1) ? 4 * col_idx + 3 : 4 * col_idx + 1;
      y0 = (row_idx == 0) ? 0 : 4 * row_idx - 2;
      y1 = (row_idx == LOW_SIDE - 1) ? 4 * row_idx + 3 : 4 * row_idx + 1;
      for (y = y0; y <= y1; y++) begin
        tap_side(y, row_idx, ya, yb, fy);
        for (x = x0; x <= x1; x++) begin
          tap_side(x, col_idx, xa, xb, fx);
          acc = (8 - fy) * ((8 - fx) * q[ya][xa] + fx * q[ya][xb])
              + fy * ((8 - fx) * q[yb][xa] + fx * q[yb][xb]);
          res = SAMPLE_BITS'((acc + 32) >> 6) ^ SIGN_BIT;
          px.x     = COORD_W'(x);
          px.y     = COORD_W'(y);
          px.value = VALUE_W'(res);
          px.last  = (y == y1) && (x == x1);
          expected_pixels.insert(expected_pixels.size(), px);
        end
      end
      up_left = up;
      line_buf[col_idx] = raw;
      left = raw;
      col_idx++;
      if (col_idx >= LOW_SIDE) begin
        col_idx = 0;
        row_idx = (row_idx + 1 >= LOW_SIDE) ? 0 : row_idx + 1;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel x=%0d y=%0d value=%h last=%b",
                   $time, got.x, got.y, got.value, got.last);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got.x !== exp_px.x || got.y !== exp_px.y || got.value !== exp_px.value ||
            got.last !== exp_px.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pixel mismatch: expected x=%0d y=%0d value=%h last=%b, %s",
                     $time, exp_px.x, exp_px.y, exp_px.value, exp_px.last,
                     $sformatf("got x=%0d y=%0d value=%h last=%b",
                               got.x, got.y, got.value, got.last));
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      sample_valid_i = 1'b0;
  logic                      sample_stall_o;
  logic signed [IN_W-1:0]    sample_value_i = '0;
  logic                      result_valid_o;
  logic                      result_stall_i = 1'b0;
  logic [COORD_W-1:0]        out_x_o;
  logic [COORD_W-1:0]        out_y_o;
  logic signed [VALUE_W-1:0] out_value_o;
  logic                      last_of_run_o;

  pixel_scoreboard sb;
  logic            idle_on = 1'b1;
  int              stall_run = 0;
  bit              stall_hold = 1'b0;

  sample_t opening_samples [22] = '{
    16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0004, 16'h0000,
    16'hFFFC, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00,
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0020, 16'hFFE0
  };

  bilinear_upsample_4x DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_value_i (sample_value_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_value_o    (out_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic sample_t next_sample();
    unique case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return sample_t'($urandom_range(0, 16)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // mostly back to back, sometimes short, rarely long
  function automatic int pick_gap(bit busy);
    int roll;
    if (!busy) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(sample_t v, int gap);
    if (gap > 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_value_i <= v;
    do @(posedge clk_i); while (sample_stall_o);
    sb.note_sample(v);
  endtask

  initial begin
    int      n;
    int      row;
    bit      busy;
    sample_t v;
    sb = new;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (n = 0; n < TOTAL_SAMPLES; n++) begin
      row  = (n / LOW_SIDE) % LOW_SIDE;
      // idle around the image borders, the wrap and a few middle rows
      busy = (n >= IMAGE_SAMPLES) || (row < 3) || (row >= LOW_SIDE - 3) || (row % 64 == 31);
      idle_on <= busy;
      v = (n < $size(opening_samples)) ? opening_samples[n] : next_sample();
      send_sample(v, pick_gap(busy));
    end
    sample_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_run = 0;
      result_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_hold = ($urandom_range(0, 9) < 3);
        if (stall_hold)
          stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
        else
          stall_run = $urandom_range(1, 24);
      end
      stall_run--;
      result_stall_i <= stall_hold;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i)
      sb.check_pixel('{x: out_x_o, y: out_y_o, value: out_value_o, last: last_of_run_o});
  end

  initial begin
    #(100_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
